>>> rtl/core/brent_line_minimizer_assert.svh
// ----------------------------------------------------------------------------
// brent_line_minimizer_assert.svh
// Assertion macros for the Brent line minimizer.
// ----------------------------------------------------------------------------
`ifndef BRENT_LINE_MINIMIZER_ASSERT_SVH
`define BRENT_LINE_MINIMIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define BLM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define BLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BLM_ASSERT_SAME(label, ante, cons, msg)
`define BLM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> rtl/core/blm_pkg.sv
// ----------------------------------------------------------------------------
// blm_pkg
// Types, codes and constants of the Brent line minimizer.
// ----------------------------------------------------------------------------
package blm_pkg;

  localparam int PW      = 32;
  localparam int ITW     = 16;
  localparam int REL_W   = 24;
  localparam int ABS_W   = 31;
  localparam int STEP_W  = 33;
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 42;
  localparam int PROD_W  = 67;
  localparam int NUM_W   = 63;
  localparam int DEN_W   = 41;
  localparam int QUO_W   = 42;
  localparam int D_W     = 54;
  localparam int SX_W    = 4;
  localparam int CFG_W   = 32;

  localparam logic signed [MUL_A_W-1:0] GOLD_Q24 = 25'sd6408326;
  localparam logic signed [STEP_W-1:0]  STEP_MAX = 33'sh0_FFFF_FFFF;
  localparam logic signed [STEP_W-1:0]  STEP_MIN = 33'sh1_0000_0000;
  localparam logic [QUO_W-1:0]          DQ_POS_MAX = 42'h100_0000_0000;
  localparam logic [QUO_W-1:0]          DQ_NEG_MAX = 42'h100_0000_0001;

  localparam logic [CFG_W-1:0] CFG_REL_TOL   = 32'd0;
  localparam logic [CFG_W-1:0] CFG_ABS_TOL   = 32'd1;
  localparam logic [CFG_W-1:0] CFG_MAX_ITER  = 32'd2;
  localparam logic [CFG_W-1:0] CFG_HAS_START = 32'd3;

  typedef enum logic {OP_START = 1'b0, OP_VALUE = 1'b1} op_t;

  typedef enum logic [2:0] {
    KIND_EVAL       = 3'd0,
    KIND_CONVERGED  = 3'd1,
    KIND_LIMIT      = 3'd2,
    KIND_ABORTED    = 3'd3,
    KIND_UNEXPECTED = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_TRIAL = 2'd2
  } phase_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LIMIT, ST_TOL, ST_CONV, ST_NORM, ST_MUL_R, ST_MUL_Q, ST_MUL_P1,
    ST_MUL_P2, ST_DIV_SETUP, ST_DIV, ST_DIV_END, ST_CHECK, ST_GOLD, ST_GOLD2,
    ST_FINAL, ST_EMIT
  } state_t;

  typedef struct packed {
    op_t                  operation;
    logic signed [PW-1:0] end_a;
    logic signed [PW-1:0] middle_b;
    logic signed [PW-1:0] end_c;
    logic signed [PW-1:0] start_value;
    logic signed [PW-1:0] func_value;
    logic                 eval_ok;
  } blm_item_t;

  typedef struct packed {
    kind_t                kind;
    logic signed [PW-1:0] point;
    logic signed [PW-1:0] best_value;
    logic [ITW-1:0]       iterations;
  } blm_result_t;

  function automatic logic [STEP_W-1:0] mag33(input logic signed [STEP_W-1:0] v);
    return v[STEP_W-1] ? STEP_W'(-v) : STEP_W'(v);
  endfunction

endpackage

>>> rtl/core/brent_line_minimizer.sv
// ----------------------------------------------------------------------------
// brent_line_minimizer
// Brent 1-D minimizer step engine around an external function evaluator.
// ----------------------------------------------------------------------------
// Usage:
// - item channel (item_valid/item_ready/item): a start transaction carries the
//   bracket end_a, middle_b, end_c and, with has_start_value set, f(middle_b);
//   each later value transaction carries f at the last requested point.
// - result channel (result_valid/result_ready/result): one transaction per item:
//   a point to evaluate, converged, iteration limit, aborted or unexpected.
// - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
//   only while the engine is idle.
// - Paths to result_valid: a restart without value, an abort and an unexpected
//   item go straight to the output; an iteration limit and convergence are
//   found by the checks before any step; a golden-section step is computed
//   directly; a parabolic step normalizes its operands, runs the radix-2
//   divider and falls back to a golden step after a rejected fit or a zero
//   denominator. One item at a time; item_ready is low while a step is in progress.
// - A finished result waits in the output register while the next item is
//   taken; the engine holds a new result until result_ready frees that slot.
// - Synchronous reset clears the search state and loads default tolerances.
// ----------------------------------------------------------------------------
`include "brent_line_minimizer_assert.svh"

module brent_line_minimizer
  import blm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  blm_item_t         item,
  output logic              result_valid,
  input  logic              result_ready,
  output blm_result_t       result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_index,
  input  logic [31:0]       cfg_data
);

  state_t state, state_next;
  phase_t phase;

  logic [REL_W-1:0] rel_tolerance;
  logic [ABS_W-1:0] abs_tolerance;
  logic [ITW-1:0]   max_iterations;
  logic             has_start_value;

  logic signed [PW-1:0] bracket_low, bracket_high;
  logic signed [PW-1:0] best_point, second_point, third_point;
  logic signed [PW-1:0] best_fvalue, second_fvalue, third_fvalue;
  logic signed [PW-1:0] trial_point;
  logic signed [STEP_W-1:0] older_step, last_step, etemp;
  logic [ITW-1:0] iteration_count;

  logic [STEP_W-1:0] tol1;
  logic signed [PROD_W-1:0] prod;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_B_W-1:0] r_val, q_val;
  logic signed [63:0] pa;

  logic [STEP_W-1:0] mxw, mxv, mfv, mfw;
  logic sgn_w, sgn_v, sgn_fv, sgn_fw;
  logic [SX_W-1:0] sx;

  logic [QUO_W-1:0] num, rem, quo;
  logic [DEN_W-1:0] den;
  logic [5:0]       div_cnt;
  logic             div_neg, div_ovf;
  logic signed [D_W-1:0] d;

  kind_t res_kind;
  logic signed [PW-1:0] res_point, res_value;

  logic load_out, accept;
  logic limit_hit, conv_hit, para_go, xfit, ffit, qq_zero, reject, tol_clip;

  logic [PW-1:0] x_mag;
  logic [STEP_W:0] tol2;
  logic signed [35:0] x36;
  logic signed [MUL_A_W-1:0] sw_val, sv_val;
  logic signed [16:0] fv_val, fw_val;
  logic signed [STEP_W-1:0] gold_e;
  logic signed [33:0] two_x, sum_ab, ab_dir;
  logic signed [63:0] p_val;
  logic [NUM_W-1:0] p_mag;
  logic signed [43:0] qq;
  logic [43:0] qq_mag;
  logic [QUO_W-1:0] rem_sh;
  logic rem_ge;
  logic signed [QUO_W:0] ds;
  logic [D_W-1:0] d_mag;
  logic signed [D_W-1:0] u54, tol1_d, tol2_d;
  logic [PROD_W-1:0] gprod_mag;
  logic signed [D_W-1:0] gold_d;
  logic signed [STEP_W-1:0] d_sat;
  logic signed [34:0] u35;
  logic signed [PW-1:0] u_sat;

  assign cfg_ready = 1'b1;
  assign accept    = item_valid && item_ready;

  // ---------------- combinational datapath helpers ----------------
  always_comb begin
    x_mag  = PW'(mag33(STEP_W'(best_point)));
    tol2   = {tol1, 1'b0};
    x36    = 36'(best_point);
    two_x  = 34'(best_point) <<< 1;
    sum_ab = 34'(bracket_low) + 34'(bracket_high);
    ab_dir = sum_ab - two_x;
    gold_e = (two_x >= sum_ab) ? STEP_W'(bracket_low) - STEP_W'(best_point)
                               : STEP_W'(bracket_high) - STEP_W'(best_point);

    limit_hit = (iteration_count >= max_iterations) || (iteration_count == '1);
    conv_hit  = (x36 <= $signed(36'(tol2)) + 36'(bracket_low)) &&
                (x36 >= 36'(bracket_high) - $signed(36'(tol2)));
    para_go   = mag33(older_step) > tol1;

    xfit = ((mxw | mxv) >> 23) == '0;
    ffit = ((mfv | mfw) >> 15) == '0;
    sw_val = sgn_w  ? -$signed({2'b0, mxw[22:0]}) : $signed({2'b0, mxw[22:0]});
    sv_val = sgn_v  ? -$signed({2'b0, mxv[22:0]}) : $signed({2'b0, mxv[22:0]});
    fv_val = sgn_fv ? -$signed({2'b0, mfv[14:0]}) : $signed({2'b0, mfv[14:0]});
    fw_val = sgn_fw ? -$signed({2'b0, mfw[14:0]}) : $signed({2'b0, mfw[14:0]});

    p_val   = pa - prod[63:0];
    p_mag   = p_val[63] ? NUM_W'(-p_val) : NUM_W'(p_val);
    qq      = (44'(q_val) - 44'(r_val)) <<< 1;
    qq_mag  = qq[43] ? 44'(-qq) : 44'(qq);
    qq_zero = (qq == '0);

    rem_sh = {rem[QUO_W-2:0], num[QUO_W-1]};
    rem_ge = rem_sh >= QUO_W'(den);

    if (div_neg) begin
      ds = (div_ovf || quo > DQ_NEG_MAX) ? -$signed({1'b0, DQ_NEG_MAX})
                                         : -$signed({1'b0, quo});
    end else begin
      ds = (div_ovf || quo > DQ_POS_MAX) ? $signed({1'b0, DQ_POS_MAX})
                                         : $signed({1'b0, quo});
    end

    d_mag  = d[D_W-1] ? D_W'(-d) : D_W'(d);
    tol1_d = $signed(D_W'(tol1));
    tol2_d = $signed(D_W'(tol2));
    u54    = d + D_W'(best_point);
    reject = ({d_mag, 1'b0} >= (D_W+1)'(mag33(etemp))) ||
             (d <= D_W'(bracket_low) - D_W'(best_point)) ||
             (d >= D_W'(bracket_high) - D_W'(best_point));
    tol_clip = (u54 - D_W'(bracket_low) < tol2_d) ||
               (D_W'(bracket_high) - u54 < tol2_d);

    gprod_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    gold_d    = prod[PROD_W-1] ? -$signed(D_W'(gprod_mag >> 24))
                               : $signed(D_W'(gprod_mag >> 24));

    if (d > D_W'(STEP_MAX)) begin
      d_sat = STEP_MAX;
    end else if (d < D_W'(STEP_MIN)) begin
      d_sat = STEP_MIN;
    end else begin
      d_sat = d[STEP_W-1:0];
    end
    if (mag33(d_sat) >= tol1) begin
      u35 = 35'(best_point) + 35'(d_sat);
    end else if (d_sat > 0) begin
      u35 = 35'(best_point) + $signed(35'(tol1));
    end else begin
      u35 = 35'(best_point) - $signed(35'(tol1));
    end
    if (u35 > 35'sh0_7FFF_FFFF) begin
      u_sat = 32'sh7FFF_FFFF;
    end else if (u35 < -35'sh0_8000_0000) begin
      u_sat = 32'sh8000_0000;
    end else begin
      u_sat = u35[PW-1:0];
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_LIMIT: begin
        mul_a = $signed(MUL_A_W'(rel_tolerance));
        mul_b = $signed(MUL_B_W'(x_mag));
      end
      ST_GOLD: begin
        mul_a = GOLD_Q24;
        mul_b = MUL_B_W'(gold_e);
      end
      ST_MUL_R: begin
        mul_a = sw_val;
        mul_b = MUL_B_W'(fv_val);
      end
      ST_MUL_Q: begin
        mul_a = sv_val;
        mul_b = MUL_B_W'(fw_val);
      end
      ST_MUL_P1: begin
        mul_a = sv_val;
        mul_b = prod[MUL_B_W-1:0];
      end
      ST_MUL_P2: begin
        mul_a = sw_val;
        mul_b = r_val;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = (state == ST_IDLE);
    load_out   = (state == ST_EMIT) && (!result_valid || result_ready);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item.operation == OP_START) begin
            state_next = has_start_value ? ST_LIMIT : ST_EMIT;
          end else if (phase != PH_START && phase != PH_TRIAL) begin
            state_next = ST_EMIT;
          end else if (!item.eval_ok) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_LIMIT;
          end
        end
      end
      ST_LIMIT:     state_next = limit_hit ? ST_EMIT : ST_TOL;
      ST_TOL:       state_next = ST_CONV;
      ST_CONV: begin
        if (conv_hit) begin
          state_next = ST_EMIT;
        end else begin
          state_next = para_go ? ST_NORM : ST_GOLD;
        end
      end
      ST_NORM:      state_next = (xfit && ffit) ? ST_MUL_R : ST_NORM;
      ST_MUL_R:     state_next = ST_MUL_Q;
      ST_MUL_Q:     state_next = ST_MUL_P1;
      ST_MUL_P1:    state_next = ST_MUL_P2;
      ST_MUL_P2:    state_next = ST_DIV_SETUP;
      ST_DIV_SETUP: state_next = qq_zero ? ST_GOLD : ST_DIV;
      ST_DIV:       state_next = (div_cnt == '0) ? ST_DIV_END : ST_DIV;
      ST_DIV_END:   state_next = ST_CHECK;
      ST_CHECK:     state_next = reject ? ST_GOLD : ST_FINAL;
      ST_GOLD:      state_next = ST_GOLD2;
      ST_GOLD2:     state_next = ST_FINAL;
      ST_FINAL:     state_next = ST_EMIT;
      ST_EMIT:      state_next = load_out ? ST_IDLE : ST_EMIT;
      default:      state_next = ST_IDLE;
    endcase
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rel_tolerance   <= 24'd16777;
      abs_tolerance   <= 31'd1;
      max_iterations  <= 16'd100;
      has_start_value <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REL_TOL:   rel_tolerance   <= cfg_data[REL_W-1:0];
        CFG_ABS_TOL:   abs_tolerance   <= cfg_data[ABS_W-1:0];
        CFG_MAX_ITER:  max_iterations  <= cfg_data[ITW-1:0];
        CFG_HAS_START: has_start_value <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- search state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bracket_low     <= '0;
      bracket_high    <= '0;
      best_point      <= '0;
      second_point    <= '0;
      third_point     <= '0;
      best_fvalue     <= '0;
      second_fvalue   <= '0;
      third_fvalue    <= '0;
      older_step      <= '0;
      last_step       <= STEP_MAX;
      trial_point     <= '0;
      iteration_count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (item.operation == OP_START) begin
              bracket_low     <= (item.end_a < item.end_c) ? item.end_a : item.end_c;
              bracket_high    <= (item.end_a > item.end_c) ? item.end_a : item.end_c;
              best_point      <= item.middle_b;
              second_point    <= item.middle_b;
              third_point     <= item.middle_b;
              older_step      <= '0;
              last_step       <= STEP_MAX;
              trial_point     <= item.middle_b;
              iteration_count <= '0;
              if (has_start_value) begin
                best_fvalue   <= item.start_value;
                second_fvalue <= item.start_value;
                third_fvalue  <= item.start_value;
              end else begin
                phase <= PH_START;
              end
            end else if (phase != PH_START && phase != PH_TRIAL) begin
              phase <= phase;
            end else if (!item.eval_ok) begin
              phase <= PH_IDLE;
            end else if (phase == PH_START) begin
              best_fvalue   <= item.func_value;
              second_fvalue <= item.func_value;
              third_fvalue  <= item.func_value;
            end else begin
              if (item.func_value <= best_fvalue) begin
                if (trial_point >= best_point) begin
                  bracket_low <= best_point;
                end else begin
                  bracket_high <= best_point;
                end
                third_point   <= second_point;
                second_point  <= best_point;
                best_point    <= trial_point;
                third_fvalue  <= second_fvalue;
                second_fvalue <= best_fvalue;
                best_fvalue   <= item.func_value;
              end else begin
                if (trial_point < best_point) begin
                  bracket_low <= trial_point;
                end else begin
                  bracket_high <= trial_point;
                end
                if (item.func_value <= second_fvalue || second_point == best_point) begin
                  third_point   <= second_point;
                  second_point  <= trial_point;
                  third_fvalue  <= second_fvalue;
                  second_fvalue <= item.func_value;
                end else if (item.func_value <= third_fvalue ||
                             third_point == best_point ||
                             third_point == second_point) begin
                  third_point  <= trial_point;
                  third_fvalue <= item.func_value;
                end
              end
              if (iteration_count != '1) begin
                iteration_count <= iteration_count + 1'b1;
              end
            end
          end
        end
        ST_LIMIT: begin
          if (limit_hit) begin
            phase <= PH_IDLE;
          end
        end
        ST_CONV: begin
          if (conv_hit) begin
            phase <= PH_IDLE;
          end
        end
        ST_DIV_SETUP: older_step <= last_step;
        ST_GOLD:      older_step <= gold_e;
        ST_FINAL: begin
          last_step   <= d_sat;
          trial_point <= u_sat;
          phase       <= PH_TRIAL;
        end
        default: ;
      endcase
    end
  end

  // ---------------- step arithmetic ----------------
  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    case (state)
      ST_TOL: tol1 <= STEP_W'(prod[55:24]) + STEP_W'(abs_tolerance);
      ST_CONV: begin
        mxw    <= mag33(STEP_W'(best_point) - STEP_W'(second_point));
        mxv    <= mag33(STEP_W'(best_point) - STEP_W'(third_point));
        mfv    <= mag33(STEP_W'(best_fvalue) - STEP_W'(third_fvalue));
        mfw    <= mag33(STEP_W'(best_fvalue) - STEP_W'(second_fvalue));
        sgn_w  <= best_point < second_point;
        sgn_v  <= best_point < third_point;
        sgn_fv <= best_fvalue < third_fvalue;
        sgn_fw <= best_fvalue < second_fvalue;
        sx     <= '0;
      end
      ST_NORM: begin
        if (!xfit) begin
          mxw <= mxw >> 1;
          mxv <= mxv >> 1;
          sx  <= sx + 1'b1;
        end
        if (!ffit) begin
          mfv <= mfv >> 1;
          mfw <= mfw >> 1;
        end
      end
      ST_MUL_Q:  r_val <= prod[MUL_B_W-1:0];
      ST_MUL_P1: q_val <= prod[MUL_B_W-1:0];
      ST_MUL_P2: pa    <= prod[63:0];
      ST_DIV_SETUP: begin
        etemp   <= older_step;
        den     <= qq_mag[DEN_W-1:0];
        div_neg <= (p_val[63] == qq[43]);
        div_ovf <= QUO_W'(p_mag[NUM_W-1:QUO_W-1]) >> 1 >= QUO_W'(qq_mag[DEN_W-1:0]);
        rem     <= QUO_W'(p_mag[NUM_W-1:QUO_W]);
        num     <= p_mag[QUO_W-1:0];
        quo     <= '0;
        div_cnt <= 6'(QUO_W - 1);
      end
      ST_DIV: begin
        rem     <= rem_ge ? rem_sh - QUO_W'(den) : rem_sh;
        quo     <= {quo[QUO_W-2:0], rem_ge};
        num     <= num << 1;
        div_cnt <= div_cnt - 1'b1;
      end
      ST_DIV_END: d <= D_W'(ds) <<< sx;
      ST_CHECK: begin
        if (!reject && tol_clip) begin
          d <= (ab_dir > 0) ? tol1_d : -tol1_d;
        end
      end
      ST_GOLD2: d <= gold_d;
      default: ;
    endcase
  end

  // ---------------- pending result ----------------
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item.operation == OP_START) begin
            res_kind  <= KIND_EVAL;
            res_point <= item.middle_b;
            res_value <= '0;
          end else if (phase != PH_START && phase != PH_TRIAL) begin
            res_kind  <= KIND_UNEXPECTED;
            res_point <= best_point;
            res_value <= best_fvalue;
          end else begin
            res_kind  <= KIND_ABORTED;
            res_point <= best_point;
            res_value <= best_fvalue;
          end
        end
      end
      ST_LIMIT: begin
        res_kind  <= KIND_LIMIT;
        res_point <= best_point;
        res_value <= best_fvalue;
      end
      ST_CONV: begin
        res_kind  <= KIND_CONVERGED;
        res_point <= best_point;
        res_value <= best_fvalue;
      end
      ST_FINAL: begin
        res_kind  <= KIND_EVAL;
        res_point <= u_sat;
        res_value <= best_fvalue;
      end
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.kind       <= res_kind;
      result.point      <= res_point;
      result.best_value <= res_value;
      result.iterations <= iteration_count;
    end
  end

  `BLM_ASSERT_SAME(a_div_rem_bound, (state == ST_DIV) && !div_ovf, rem < QUO_W'(den), "divider remainder out of range")
  `BLM_ASSERT_SAME(a_norm_shift, state == ST_NORM, sx <= 4'd9, "normalization shift too large")
  `BLM_ASSERT_NEXT(a_eval_phase, load_out && res_kind == KIND_EVAL, phase != PH_IDLE, "point request with idle phase")
  `BLM_ASSERT_NEXT(a_iter_mono, accept && item.operation == OP_VALUE, iteration_count >= $past(iteration_count), "iteration count went down")

endmodule
